/* rtl/nst_pkg.sv */
// ----------------------------------------------------------------------------
// nst_pkg
// types and constants shared by the note state tracker
// ----------------------------------------------------------------------------
package nst_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int CHANNEL_COUNT = 16;
  localparam int NOTE_W        = $clog2(NOTE_COUNT);
  localparam int CHAN_W        = $clog2(CHANNEL_COUNT);
  localparam int COUNT_W       = 8;

  // ump message types
  localparam logic [3:0] MT_MIDI1_VOICE = 4'h2;
  localparam logic [3:0] MT_MIDI2_VOICE = 4'h4;

  // channel voice status codes
  localparam logic [3:0] STS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STS_CTRL     = 4'hB;

  localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

  // operation field
  localparam logic OPER_PACKET = 1'b0;
  localparam logic OPER_QUERY  = 1'b1;

  // event kinds
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
  localparam logic [1:0] KIND_ALL_OFF  = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [CHAN_W-1:0]        channel;
    logic [NOTE_W-1:0]        note;
    logic [15:0]              velocity;
    logic                     wide;
    logic [COUNT_W-1:0]       cleared;
    logic                     hit;
    logic [CHANNEL_COUNT-1:0] mask;
  } result_t;

  typedef struct packed {
    logic                     we;
    logic [NOTE_W-1:0]        waddr;
    logic [CHANNEL_COUNT-1:0] wdata;
    logic                     re;
    logic [NOTE_W-1:0]        raddr;
  } ram_req_t;

endpackage

/* rtl/nst_in_if.sv */
// ----------------------------------------------------------------------------
// nst_in_if
// input channel: one query or one packet per transaction
// ----------------------------------------------------------------------------
interface nst_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] packet_word0;
  logic [31:0] packet_word1;
  logic [6:0]  query_note;
  logic [15:0] query_channel_mask;

  modport source (
    output valid, operation, packet_word0, packet_word1, query_note, query_channel_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, packet_word0, packet_word1, query_note, query_channel_mask,
    output ready
  );
endinterface

/* rtl/nst_out_if.sv */
// ----------------------------------------------------------------------------
// nst_out_if
// result channel: one result per transaction
// ----------------------------------------------------------------------------
interface nst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [3:0]  event_channel;
  logic [6:0]  event_note;
  logic [15:0] event_velocity;
  logic        velocity_wide;
  logic [7:0]  notes_cleared;
  logic        query_hit;
  logic [15:0] note_mask;

  modport source (
    output valid, event_kind, event_channel, event_note, event_velocity, velocity_wide,
           notes_cleared, query_hit, note_mask,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_channel, event_note, event_velocity, velocity_wide,
           notes_cleared, query_hit, note_mask,
    output ready
  );
endinterface

/* rtl/nst_ram.sv */
// ----------------------------------------------------------------------------
// nst_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module nst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nst_core.sv */
// ----------------------------------------------------------------------------
// nst_core
// decode, read-modify-write sequencer, all-notes-off sweep and result register
// ----------------------------------------------------------------------------
module nst_core
  import nst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  nst_in_if.sink                   in_ch,
  nst_out_if.source                out_ch,
  input  logic [3:0]               group_sel,
  output ram_req_t                 ram_req,
  input  logic [CHANNEL_COUNT-1:0] ram_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;

  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_QUERY    = 3'd1;
  localparam logic [2:0] OP_NOTE_ON  = 3'd2;
  localparam logic [2:0] OP_NOTE_OFF = 3'd3;
  localparam logic [2:0] OP_ALL_OFF  = 3'd4;

  localparam int SWEEP_W = NOTE_W + 1;

  logic [2:0]               state_r, state_nxt;
  logic [2:0]               op_r, op_nxt;
  logic [NOTE_W-1:0]        addr_r, addr_nxt;
  logic [CHAN_W-1:0]        chan_r, chan_nxt;
  logic [15:0]              vel_r, vel_nxt;
  logic                     wide_r, wide_nxt;
  logic [CHANNEL_COUNT-1:0] qmask_r, qmask_nxt;
  logic [SWEEP_W-1:0]       cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [NOTE_W-1:0]        pend_addr_r, pend_addr_nxt;
  logic [COUNT_W-1:0]       cleared_r, cleared_nxt;
  logic [NOTE_COUNT-1:0]    valid_r, valid_nxt;
  result_t                  res_r, res_nxt;
  result_t                  out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [3:0]               w0_type, w0_group, w0_status, w0_chan;
  logic [7:0]               w0_byte2;
  logic                     tracked;
  logic [15:0]              in_vel;
  logic                     accept;
  logic [2:0]               dec_op;
  logic [CHANNEL_COUNT-1:0] chan_bit;
  logic [CHANNEL_COUNT-1:0] cur_mask;
  logic [CHANNEL_COUNT-1:0] sweep_mask;

  assign w0_type   = in_ch.packet_word0[31:28];
  assign w0_group  = in_ch.packet_word0[27:24];
  assign w0_status = in_ch.packet_word0[23:20];
  assign w0_chan   = in_ch.packet_word0[19:16];
  assign w0_byte2  = in_ch.packet_word0[15:8];
  assign tracked   = (w0_type == MT_MIDI1_VOICE || w0_type == MT_MIDI2_VOICE) &&
                     (w0_group == group_sel);
  assign in_vel    = (w0_type == MT_MIDI1_VOICE) ? {8'd0, in_ch.packet_word0[7:0]}
                                                 : in_ch.packet_word1[31:16];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    dec_op = OP_NONE;
    if (in_ch.operation == OPER_QUERY) begin
      dec_op = OP_QUERY;
    end else if (tracked && (w0_status == STS_NOTE_ON || w0_status == STS_NOTE_OFF) &&
                 !w0_byte2[7]) begin
      dec_op = (w0_status == STS_NOTE_ON && in_vel != 16'd0) ? OP_NOTE_ON : OP_NOTE_OFF;
    end else if (tracked && w0_status == STS_CTRL && w0_byte2 == CC_ALL_NOTES_OFF) begin
      dec_op = OP_ALL_OFF;
    end
  end

  assign chan_bit   = CHANNEL_COUNT'(1) << chan_r;
  // entries never written read as zero
  assign cur_mask   = valid_r[addr_r] ? ram_rdata : '0;
  assign sweep_mask = valid_r[pend_addr_r] ? ram_rdata : '0;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    chan_nxt      = chan_r;
    vel_nxt       = vel_r;
    wide_nxt      = wide_r;
    qmask_nxt     = qmask_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cleared_nxt   = cleared_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_req       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = dec_op;
          chan_nxt  = w0_chan;
          vel_nxt   = in_vel;
          wide_nxt  = (w0_type == MT_MIDI2_VOICE);
          qmask_nxt = in_ch.query_channel_mask;
          addr_nxt  = (dec_op == OP_QUERY) ? in_ch.query_note : w0_byte2[NOTE_W-1:0];
          case (dec_op)
            OP_QUERY, OP_NOTE_ON, OP_NOTE_OFF: begin
              ram_req.re    = 1'b1;
              ram_req.raddr = (dec_op == OP_QUERY) ? in_ch.query_note
                                                   : w0_byte2[NOTE_W-1:0];
              state_nxt     = ST_EXEC;
            end
            OP_ALL_OFF: begin
              cnt_nxt     = '0;
              pend_nxt    = 1'b0;
              cleared_nxt = '0;
              state_nxt   = ST_SWEEP;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        res_nxt   = '0;
        state_nxt = ST_DONE;
        case (op_r)
          OP_QUERY: begin
            res_nxt.hit  = |(cur_mask & qmask_r);
            res_nxt.mask = cur_mask;
          end
          OP_NOTE_ON: begin
            ram_req.we       = 1'b1;
            ram_req.waddr    = addr_r;
            ram_req.wdata    = cur_mask | chan_bit;
            valid_nxt[addr_r] = 1'b1;
            res_nxt.kind     = KIND_NOTE_ON;
            res_nxt.channel  = chan_r;
            res_nxt.note     = addr_r;
            res_nxt.velocity = vel_r;
            res_nxt.wide     = wide_r;
            res_nxt.mask     = cur_mask | chan_bit;
          end
          OP_NOTE_OFF: begin
            if ((cur_mask & chan_bit) != '0) begin
              ram_req.we       = 1'b1;
              ram_req.waddr    = addr_r;
              ram_req.wdata    = cur_mask & ~chan_bit;
              valid_nxt[addr_r] = 1'b1;
              res_nxt.kind     = KIND_NOTE_OFF;
              res_nxt.channel  = chan_r;
              res_nxt.note     = addr_r;
              res_nxt.velocity = vel_r;
              res_nxt.wide     = wide_r;
              res_nxt.mask     = cur_mask & ~chan_bit;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SWEEP: begin
        // read entry cnt while writing back the entry read in the previous cycle
        if (!cnt_r[SWEEP_W-1]) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cnt_r[NOTE_W-1:0];
          cnt_nxt       = cnt_r + SWEEP_W'(1);
        end
        pend_nxt      = !cnt_r[SWEEP_W-1];
        pend_addr_nxt = cnt_r[NOTE_W-1:0];
        if (pend_r) begin
          ram_req.we             = 1'b1;
          ram_req.waddr          = pend_addr_r;
          ram_req.wdata          = sweep_mask & ~chan_bit;
          valid_nxt[pend_addr_r] = 1'b1;
          if ((sweep_mask & chan_bit) != '0) begin
            cleared_nxt = cleared_r + COUNT_W'(1);
          end
        end
        if (cnt_r[SWEEP_W-1] && !pend_r) begin
          res_nxt         = '0;
          res_nxt.kind    = KIND_ALL_OFF;
          res_nxt.channel = chan_r;
          res_nxt.cleared = cleared_r;
          state_nxt       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    chan_r      <= chan_nxt;
    vel_r       <= vel_nxt;
    wide_r      <= wide_nxt;
    qmask_r     <= qmask_nxt;
    cnt_r       <= cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    cleared_r   <= cleared_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = out_r.kind;
  assign out_ch.event_channel  = out_r.channel;
  assign out_ch.event_note     = out_r.note;
  assign out_ch.event_velocity = out_r.velocity;
  assign out_ch.velocity_wide  = out_r.wide;
  assign out_ch.notes_cleared  = out_r.cleared;
  assign out_ch.query_hit      = out_r.hit;
  assign out_ch.note_mask      = out_r.mask;

endmodule

/* rtl/midi_note_state_tracker.sv */
// ----------------------------------------------------------------------------
// midi_note_state_tracker
// per-note channel masks kept in a 128 x 16 ram, updated by ump note
// packets and all-notes-off, and answered by note queries
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | operation, packet words, query note and mask
//  out_ch   | out | valid / ready | event fields, cleared count, hit, note mask
//  cfg_*    | in  | cfg_we        | group_select in cfg_wdata
//
// query, note-on and note-off: accept, read-modify-write, result
// ignored packet: accept, result; all-notes-off: a sweep of one ram entry
// per cycle through the single read port
// reset clears a valid flag per note at once, no clearing pass
// a finished result waits in the output register; the next transaction is
// taken once the result has moved there
// ----------------------------------------------------------------------------
module midi_note_state_tracker
  import nst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nst_in_if.sink     in_ch,
  nst_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic [3:0]               group_r;
  ram_req_t                 ram_req;
  logic [CHANNEL_COUNT-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
    end else if (cfg_we) begin
      group_r <= cfg_wdata;
    end
  end

  nst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .group_sel (group_r),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  nst_ram #(
    .WIDTH (CHANNEL_COUNT),
    .DEPTH (NOTE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/nst_checker.sv */
// ----------------------------------------------------------------------------
// nst_checker
// port-level checks on the result channel of the note state tracker
// ----------------------------------------------------------------------------
module nst_checker
  import nst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [3:0]  event_channel,
  input logic [6:0]  event_note,
  input logic [15:0] event_velocity,
  input logic        query_hit,
  input logic [15:0] note_mask
);

  property p_valid_holds;
    @(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid;
  endproperty
  a_valid_holds: assert property (p_valid_holds) else $error("result dropped while stalled");

  property p_hit_only_on_query;
    @(posedge clk) disable iff (!rst_n)
      out_valid && query_hit |-> event_kind == KIND_NONE;
  endproperty
  a_hit_only_on_query: assert property (p_hit_only_on_query)
    else $error("query hit on an event result");

  property p_all_off_clean;
    @(posedge clk) disable iff (!rst_n)
      out_valid && event_kind == KIND_ALL_OFF |->
        note_mask == '0 && event_velocity == '0 && event_note == '0;
  endproperty
  a_all_off_clean: assert property (p_all_off_clean)
    else $error("all-notes-off result carries note fields");

  property p_note_on_bit_set;
    @(posedge clk) disable iff (!rst_n)
      out_valid && event_kind == KIND_NOTE_ON |-> ((note_mask >> event_channel) & 16'd1) != '0;
  endproperty
  a_note_on_bit_set: assert property (p_note_on_bit_set)
    else $error("note-on result without its channel bit");

  property p_note_off_bit_clear;
    @(posedge clk) disable iff (!rst_n)
      out_valid && event_kind == KIND_NOTE_OFF |->
        ((note_mask >> event_channel) & 16'd1) == '0;
  endproperty
  a_note_off_bit_clear: assert property (p_note_off_bit_clear)
    else $error("note-off result with its channel bit still set");

endmodule

bind midi_note_state_tracker nst_checker u_nst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_kind     (out_ch.event_kind),
  .event_channel  (out_ch.event_channel),
  .event_note     (out_ch.event_note),
  .event_velocity (out_ch.event_velocity),
  .query_hit      (out_ch.query_hit),
  .note_mask      (out_ch.note_mask)
);

/* sim/midi_note_state_tracker_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_state_tracker_chk
// watches the input, result and configuration ports of the note state
// tracker, keeps its own copy of the per-note channel masks and the tracked
// group, predicts the result of every accepted transaction and compares
// each accepted result field by field, in order
// ----------------------------------------------------------------------------
module midi_note_state_tracker_chk
  import nst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nst_in_if          in_mon,
  nst_out_if         out_mon,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         results_seen
);

  logic [CHANNEL_COUNT-1:0] held_masks [NOTE_COUNT];
  logic [3:0]               tracked_group;
  result_t                  pending_results [$];
  int                       mismatches   = 0;
  int                       result_total = 0;

  function automatic result_t track_note_state(logic op, logic [31:0] w0, logic [31:0] w1,
                                               logic [NOTE_W-1:0] qnote, logic [15:0] qmask);
    result_t                  r;
    logic [3:0]               mt;
    logic [3:0]               grp;
    logic [3:0]               sts;
    logic [CHAN_W-1:0]        ch;
    logic [7:0]               b2;
    logic [NOTE_W-1:0]        nt;
    logic [CHANNEL_COUNT-1:0] chbit;
    logic [15:0]              vel;
    logic                     wide;
    logic [COUNT_W-1:0]       count;
    r = '0;
    if (op == OPER_QUERY) begin
      r.hit  = |(held_masks[qnote] & qmask);
      r.mask = held_masks[qnote];
      return r;
    end
    mt    = w0[31:28];
    grp   = w0[27:24];
    sts   = w0[23:20];
    ch    = w0[19:16];
    b2    = w0[15:8];
    chbit = '0;
    chbit[ch] = 1'b1;
    if ((mt != MT_MIDI1_VOICE && mt != MT_MIDI2_VOICE) || grp != tracked_group)
      return r;
    if (sts == STS_NOTE_OFF || sts == STS_NOTE_ON) begin
      if (b2[7])
        return r;
      nt = b2[NOTE_W-1:0];
      if (mt == MT_MIDI1_VOICE) begin
        vel  = {8'h00, w0[7:0]};
        wide = 1'b0;
      end else begin
        vel  = w1[31:16];
        wide = 1'b1;
      end
      if (sts == STS_NOTE_ON && vel != 16'h0000) begin
        held_masks[nt] = held_masks[nt] | chbit;
        r.kind = KIND_NOTE_ON;
      end else if ((held_masks[nt] & chbit) != '0) begin
        held_masks[nt] = held_masks[nt] & ~chbit;
        r.kind = KIND_NOTE_OFF;
      end else begin
        return r;
      end
      r.channel  = ch;
      r.note     = nt;
      r.velocity = vel;
      r.wide     = wide;
      r.mask     = held_masks[nt];
    end else if (sts == STS_CTRL && b2 == CC_ALL_NOTES_OFF) begin
      count = '0;
      for (int i = 0; i < NOTE_COUNT; i++) begin
        if ((held_masks[i] & chbit) != '0) begin
          held_masks[i] = held_masks[i] & ~chbit;
          count++;
        end
      end
      r.kind    = KIND_ALL_OFF;
      r.channel = ch;
      r.cleared = count;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      foreach (held_masks[i])
        held_masks[i] = '0;
      tracked_group = '0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind     = out_mon.event_kind;
        got.channel  = out_mon.event_channel;
        got.note     = out_mon.event_note;
        got.velocity = out_mon.event_velocity;
        got.wide     = out_mon.velocity_wide;
        got.cleared  = out_mon.notes_cleared;
        got.hit      = out_mon.query_hit;
        got.mask     = out_mon.note_mask;
        result_total++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("event_kind", want.kind, got.kind);
          compare_field("event_channel", want.channel, got.channel);
          compare_field("event_note", want.note, got.note);
          compare_field("event_velocity", want.velocity, got.velocity);
          compare_field("velocity_wide", want.wide, got.wide);
          compare_field("notes_cleared", want.cleared, got.cleared);
          compare_field("query_hit", want.hit, got.hit);
          compare_field("note_mask", want.mask, got.mask);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(track_note_state(in_mon.operation, in_mon.packet_word0,
                                                   in_mon.packet_word1, in_mon.query_note,
                                                   in_mon.query_channel_mask));
      if (cfg_we)
        tracked_group = cfg_wdata;
    end
    fail_count   <= mismatches;
    results_seen <= result_total;
  end

endmodule

/* sim/midi_note_state_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_state_tracker_tb
// drives directed and random ump packets and note queries into the note
// state tracker across several tracked groups, with random gaps on the
// input and random stalls on the result side; a separate checker predicts
// and compares every result, this module makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module midi_note_state_tracker_tb;
  import nst_pkg::*;

  localparam int QUIET_LIMIT    = 5000;
  localparam int ITEMS_PER_PASS = 220;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic [3:0] cur_group;
  logic       steady = 1'b0;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  int         fail_count;
  int         results_seen;

  nst_in_if  in_if ();
  nst_out_if out_if ();

  midi_note_state_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  midi_note_state_tracker_chk i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // mostly a small set of notes so that offs and queries find held notes
  function automatic logic [7:0] pick_note();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)
      return 8'($urandom_range(128, 255));
    if (roll < 50)
      return 8'($urandom_range(60, 67));
    if (roll < 56)
      return $urandom_range(0, 1) ? 8'd127 : 8'd0;
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [3:0] pick_channel();
    if ($urandom_range(0, 99) < 60)
      return 4'($urandom_range(0, 3));
    return 4'($urandom);
  endfunction

  task automatic send_item(logic op, logic [31:0] w0, logic [31:0] w1,
                           logic [6:0] qnote, logic [15:0] qmask);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid              <= 1'b1;
    in_if.operation          <= op;
    in_if.packet_word0       <= w0;
    in_if.packet_word1       <= w1;
    in_if.query_note         <= qnote;
    in_if.query_channel_mask <= qmask;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_packet(logic [3:0] mt, logic [3:0] grp, logic [3:0] sts, logic [3:0] ch,
                             logic [7:0] b2, logic [7:0] lo8, logic [31:0] w1);
    send_item(OPER_PACKET, {mt, grp, sts, ch, b2, lo8}, w1, 7'($urandom), 16'($urandom));
  endtask

  task automatic send_query(logic [6:0] qnote, logic [15:0] qmask);
    send_item(OPER_QUERY, $urandom, $urandom, qnote, qmask);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("midi_note_state_tracker_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int         counted;
    int         sel;
    logic [3:0] mt;
    logic [3:0] ch;
    logic [3:0] sweep_ch;
    logic [7:0] nt;
    logic [7:0] lo8;
    logic [31:0] w1;
    logic [15:0] qmask;

    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_wdata                <= '0;
    in_if.valid              <= 1'b0;
    in_if.operation          <= OPER_PACKET;
    in_if.packet_word0       <= '0;
    in_if.packet_word1       <= '0;
    in_if.query_note         <= '0;
    in_if.query_channel_mask <= '0;
    cur_group = 4'h0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, tracked group at its reset value
    send_query(7'd0, 16'hFFFF);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'h0, 8'd0, 8'h7F, 32'h0);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'hF, 8'd127, 8'hFF, 32'h0);
    send_packet(MT_MIDI2_VOICE, cur_group, STS_NOTE_ON, 4'h5, 8'd127, 8'h00, 32'hFFFF_FFFF);
    send_query(7'd127, 16'h8000);
    send_query(7'd127, 16'h7FDF);
    send_query(7'd127, 16'h0000);
    // zero velocity on a note-on releases the note
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'hF, 8'd127, 8'h00, 32'hFFFF_FFFF);
    send_packet(MT_MIDI2_VOICE, cur_group, STS_NOTE_OFF, 4'h5, 8'd127, 8'hFF, 32'h1234_5678);
    // releases of notes that are not held
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_OFF, 4'h3, 8'd0, 8'h40, 32'h0);
    send_packet(MT_MIDI2_VOICE, cur_group, STS_NOTE_ON, 4'h3, 8'd0, 8'hFF, 32'h0000_FFFF);
    // note numbers out of range
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'h0, 8'h80, 8'h7F, 32'h0);
    send_packet(MT_MIDI2_VOICE, cur_group, STS_NOTE_OFF, 4'h0, 8'hFF, 8'h00, 32'hFFFF_0000);
    // foreign group, foreign types, other status, other controller
    send_packet(MT_MIDI1_VOICE, 4'h1, STS_NOTE_ON, 4'h0, 8'd10, 8'h7F, 32'h0);
    send_packet(4'h1, cur_group, STS_NOTE_ON, 4'h0, 8'd10, 8'h7F, 32'hFFFF_FFFF);
    send_packet(4'hF, cur_group, STS_NOTE_ON, 4'h0, 8'd10, 8'h7F, 32'hFFFF_FFFF);
    send_packet(MT_MIDI1_VOICE, cur_group, 4'hA, 4'h0, 8'd0, 8'h7F, 32'h0);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_CTRL, 4'h0, 8'd122, 8'h00, 32'h0);
    // all notes off with several, one and no held notes
    send_packet(MT_MIDI2_VOICE, cur_group, STS_NOTE_ON, 4'h2, 8'd1, 8'h00, 32'h8000_0000);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'h2, 8'd2, 8'h01, 32'h0);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_NOTE_ON, 4'h2, 8'd127, 8'h01, 32'h0);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_CTRL, 4'h2, CC_ALL_NOTES_OFF, 8'h00, 32'h0);
    send_packet(MT_MIDI2_VOICE, cur_group, STS_CTRL, 4'h0, CC_ALL_NOTES_OFF, 8'hFF, 32'hFFFF_FFFF);
    send_packet(MT_MIDI1_VOICE, cur_group, STS_CTRL, 4'h0, CC_ALL_NOTES_OFF, 8'h00, 32'h0);
    send_query(7'd0, 16'hFFFF);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1, 5:    cur_group = 4'hF;
          3:       cur_group = 4'h0;
          default: cur_group = 4'($urandom_range(1, 14));
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= cur_group;
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      steady  = (phase == 2);
      counted = 0;
      // hold one channel on every note, then release it in one sweep
      if (phase == 5) begin
        sweep_ch = 4'($urandom);
        for (int n = 0; n < NOTE_COUNT; n++)
          send_packet($urandom_range(0, 1) ? MT_MIDI2_VOICE : MT_MIDI1_VOICE, cur_group,
                      STS_NOTE_ON, sweep_ch, 8'(n), 8'($urandom_range(1, 255)),
                      {16'($urandom_range(1, 65535)), 16'($urandom)});
        send_query(7'($urandom), 16'h0001 << sweep_ch);
        send_packet(MT_MIDI1_VOICE, cur_group, STS_CTRL, sweep_ch, CC_ALL_NOTES_OFF,
                    8'($urandom), $urandom);
        counted += NOTE_COUNT + 2;
      end
      while (counted < ITEMS_PER_PASS) begin
        sel = $urandom_range(0, 99);
        mt  = $urandom_range(0, 1) ? MT_MIDI2_VOICE : MT_MIDI1_VOICE;
        ch  = pick_channel();
        nt  = pick_note();
        lo8 = 8'($urandom);
        w1  = $urandom;
        if (sel < 18) begin
          case ($urandom_range(0, 9))
            0, 1, 2: qmask = 16'h0001 << ch;
            3:       qmask = 16'hFFFF;
            4:       qmask = 16'h0000;
            default: qmask = 16'($urandom);
          endcase
          send_query(nt[6:0], qmask);
        end else if (sel < 74) begin
          if (sel < 46 && $urandom_range(0, 19) == 0) begin
            lo8       = 8'h00;
            w1[31:16] = 16'h0000;
          end
          if (sel < 70)
            send_packet(mt, cur_group, (sel < 46) ? STS_NOTE_ON : STS_NOTE_OFF, ch, nt, lo8, w1);
          else
            send_packet(mt, cur_group, STS_CTRL, ch, CC_ALL_NOTES_OFF, lo8, w1);
        end else if (sel < 80) begin
          send_packet(mt, cur_group, STS_CTRL, ch, 8'($urandom), lo8, w1);
        end else if (sel < 86) begin
          send_packet(mt, cur_group + 4'($urandom_range(1, 15)),
                      $urandom_range(0, 1) ? STS_NOTE_ON : STS_NOTE_OFF, ch, nt, lo8, w1);
        end else if (sel < 92) begin
          send_packet(4'($urandom), cur_group, 4'($urandom), ch, nt, lo8, w1);
        end else begin
          send_item(OPER_PACKET, $urandom, $urandom, 7'($urandom), 16'($urandom));
        end
        counted++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("midi_note_state_tracker_tb: done, clean");
    else
      $display("midi_note_state_tracker_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/nst_pkg.sv
rtl/nst_in_if.sv
rtl/nst_out_if.sv
rtl/nst_ram.sv
rtl/nst_core.sv
rtl/midi_note_state_tracker.sv
rtl/nst_checker.sv
sim/midi_note_state_tracker_chk.sv
sim/midi_note_state_tracker_tb.sv
